// File: design/vmsf_pkg.sv
// ============================================================================
// vmsf_pkg
// Shared types and constants of the volume median sign filter.
// ============================================================================
`default_nettype none

package vmsf_pkg;

  // Address field width that covers the largest supported ring store
  localparam int ADDR_WM = 26;

  // Input item kind
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } opcode_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_ENABLE = 3'd0;
  localparam logic [2:0] CFG_DIM_I  = 3'd1;
  localparam logic [2:0] CFG_DIM_J  = 3'd2;
  localparam logic [2:0] CFG_DIM_K  = 3'd3;
  localparam logic [2:0] CFG_LIMIT  = 3'd4;

  // Register file contents
  typedef struct packed {
    logic        en;
    logic [15:0] dim_i;
    logic [8:0]  dim_j;
    logic [8:0]  dim_k;
    logic [30:0] limit;
  } cfg_t;

  // Command handed from the front end to the back end
  typedef struct packed {
    logic               wr_en;
    logic [31:0]        wr_data;
    logic [ADDR_WM-1:0] wr_addr;
    logic               emit;
    logic               filt;
    logic               vol_end;
    logic [ADDR_WM-1:0] slot;
    logic [ADDR_WM-1:0] plane;
    logic [8:0]         row;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/vmsf_queue.sv
// ============================================================================
// vmsf_queue
// Small command FIFO between the front end and the back end.
// ============================================================================
`default_nettype none

module vmsf_queue
  import vmsf_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic push_i,
  input  wire  cmd_t push_data_i,
  output logic       full_o,
  input  wire  logic pop_i,
  output logic       valid_o,
  output cmd_t       head_o
);

  cmd_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// File: design/vmsf_front.sv
// ============================================================================
// vmsf_front
// Accepts items, tracks ring pointer, pending count and emit position, and
// decides for each item whether a voxel is emitted and whether it may filter.
// ============================================================================
`default_nettype none

module vmsf_front
  import vmsf_pkg::*;
#(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  cfg_t        cfg_i,
  input  wire  logic        valid_i,
  output logic              ready_o,
  input  wire  logic        opcode_i,
  input  wire  logic [31:0] depth_i,
  input  wire  logic        full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  localparam int DEPTH = 2 * MAX_ROWS * MAX_ROW_LEN + 2 * MAX_ROW_LEN + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;
  localparam int CW    = AW + 2;

  logic [AW-1:0] wr_q, wr_inc, wr_n;
  logic [PW-1:0] pend_q, pend_inc, pend_n;
  logic [15:0]   ei_q, ni;
  logic [8:0]    ej_q, ek_q, nj, nk;
  logic [17:0]   plane;
  logic [18:0]   lag;
  logic [CW-1:0] diff, slot;
  logic          is_data, emit, accept, in_i, in_j, in_k;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign is_data = (opcode_i == OP_SAMPLE);

  // clamped dimensions and lag
  always_comb begin
    ni = (cfg_i.dim_i == 16'd0) ? 16'd1 : cfg_i.dim_i;
    if (cfg_i.dim_j == 9'd0)                      nj = 9'd1;
    else if (32'(cfg_i.dim_j) > 32'(MAX_ROWS))    nj = 9'(MAX_ROWS);
    else                                          nj = cfg_i.dim_j;
    if (cfg_i.dim_k == 9'd0)                      nk = 9'd1;
    else if (32'(cfg_i.dim_k) > 32'(MAX_ROW_LEN)) nk = 9'(MAX_ROW_LEN);
    else                                          nk = cfg_i.dim_k;
    plane = {9'b0, nj} * {9'b0, nk};
    lag   = {1'b0, plane} + {10'b0, nk} + 19'd1;
  end

  // pointer and pending updates, emit decision, slot of the oldest voxel
  always_comb begin
    wr_inc   = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    pend_inc = (pend_q < PW'(DEPTH)) ? pend_q + 1'b1 : pend_q;
    if (is_data) begin
      wr_n   = wr_inc;
      pend_n = pend_inc;
      emit   = (32'(pend_inc) > 32'(lag));
    end else begin
      wr_n   = wr_q;
      pend_n = pend_q;
      emit   = (pend_q != '0);
    end
    diff = {2'b0, wr_n} - {1'b0, pend_n};
    slot = diff[CW-1] ? diff + CW'(DEPTH) : diff;
    in_i = (ei_q != 16'd0) && ({1'b0, ei_q} + 17'd1 < {1'b0, ni});
    in_j = (ej_q != 9'd0)  && ({1'b0, ej_q} + 10'd1 < {1'b0, nj});
    in_k = (ek_q != 9'd0)  && ({1'b0, ek_q} + 10'd1 < {1'b0, nk});
  end

  // command
  always_comb begin
    cmd_o.wr_en   = is_data;
    cmd_o.wr_data = depth_i;
    cmd_o.wr_addr = ADDR_WM'(wr_q);
    cmd_o.emit    = emit;
    cmd_o.filt    = is_data && cfg_i.en && in_i && in_j && in_k;
    cmd_o.vol_end = ({1'b0, ei_q} + 17'd1 == {1'b0, ni}) &&
                    ({1'b0, ej_q} + 10'd1 == {1'b0, nj}) &&
                    ({1'b0, ek_q} + 10'd1 == {1'b0, nk});
    cmd_o.slot    = ADDR_WM'(slot[AW-1:0]);
    cmd_o.plane   = ADDR_WM'(plane);
    cmd_o.row     = nk;
    push_o        = accept && (is_data || emit);
  end

  // state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      pend_q <= '0;
      ei_q   <= '0;
      ej_q   <= '0;
      ek_q   <= '0;
    end else if (accept) begin
      wr_q <= wr_n;
      if (emit) begin
        pend_q <= pend_n - 1'b1;
        if ({1'b0, ek_q} + 10'd1 < {1'b0, nk}) begin
          ek_q <= ek_q + 9'd1;
        end else begin
          ek_q <= '0;
          if ({1'b0, ej_q} + 10'd1 < {1'b0, nj}) begin
            ej_q <= ej_q + 9'd1;
          end else begin
            ej_q <= '0;
            ei_q <= ({1'b0, ei_q} + 17'd1 < {1'b0, ni}) ? ei_q + 16'd1 : 16'd0;
          end
        end
      end else begin
        pend_q <= pend_n;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/vmsf_back.sv
// ============================================================================
// vmsf_back
// Executes commands: writes samples to the ring store, reads the 27-voxel
// window one word a cycle into an insertion sorter, applies the sign test,
// writes the median back and drives the output register.
// ============================================================================
`default_nettype none

module vmsf_back
  import vmsf_pkg::*;
#(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  cfg_t        cfg_i,
  input  wire  logic        q_valid_i,
  input  wire  cmd_t        cmd_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  wire  logic        m_ready_i,
  output logic [31:0]       m_depth_o,
  output logic              m_replaced_o,
  output logic              m_last_o
);

  localparam int DEPTH = 2 * MAX_ROWS * MAX_ROW_LEN + 2 * MAX_ROW_LEN + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 2;

  typedef enum logic [1:0] {S_IDLE, S_RD, S_LAST, S_DEC} state_e;

  logic [31:0]        mem [DEPTH];
  state_e             state_q;
  cmd_t               cmd_q;
  logic [4:0]         idx_q, cnt_q;
  logic [1:0]         a_q, b_q, c_q;
  logic signed [31:0] win_q [27];
  logic signed [31:0] win_d [27];
  logic signed [31:0] rdata_q, d_q, med;
  logic [26:0]        gt;
  logic [26:0]        gt_sh;
  logic               we, re, out_free, elig, differ;
  logic [AW-1:0]      wa, ra;
  logic [31:0]        wd;
  logic [CW-1:0]      ta, tb, tc, sum, waddr;
  logic [32:0]        d_ext, lim_ext;

  assign out_free = !m_valid_o || m_ready_i;
  assign med      = win_q[13];

  // window address: slot plus plane, row and column offsets, wrapped
  always_comb begin
    ta = (a_q == 2'd0) ? -CW'(cmd_q.plane[AW-1:0]) :
         (a_q == 2'd2) ?  CW'(cmd_q.plane[AW-1:0]) : '0;
    tb = (b_q == 2'd0) ? -CW'(cmd_q.row) : (b_q == 2'd2) ? CW'(cmd_q.row) : '0;
    tc = (c_q == 2'd0) ? '1 : (c_q == 2'd2) ? CW'(1) : '0;
    sum = CW'(cmd_q.slot[AW-1:0]) + ta + tb + tc;
    if (sum[CW-1])                waddr = sum + CW'(DEPTH);
    else if (sum >= CW'(DEPTH))   waddr = sum - CW'(DEPTH);
    else                          waddr = sum;
  end

  // insertion of the returned word into the sorted window
  always_comb begin
    for (int p = 0; p < 27; p++) begin
      gt[p] = (5'(p) < cnt_q) && (win_q[p] > rdata_q);
    end
    // neighbor below each position moves up
    gt_sh = {gt[25:0], 1'b0};
    for (int p = 0; p < 27; p++) begin
      if ((5'(p) < cnt_q) && !gt[p])  win_d[p] = win_q[p];
      else if (gt_sh[p])              win_d[p] = win_q[(p > 0) ? p - 1 : 0];
      else                            win_d[p] = rdata_q;
    end
  end

  // sign test against the median
  always_comb begin
    d_ext   = {d_q[31], d_q};
    lim_ext = {2'b0, cfg_i.limit};
    elig    = cmd_q.filt && ($signed(d_ext) < $signed(lim_ext)) &&
              ($signed(d_ext) > -$signed(lim_ext));
    differ  = (med[31] != d_q[31]) || ((med == 32'sd0) != (d_q == 32'sd0));
  end

  // memory port control
  always_comb begin
    pop_o = (state_q == S_IDLE) && q_valid_i;
    we    = 1'b0;
    wa    = cmd_i.wr_addr[AW-1:0];
    wd    = cmd_i.wr_data;
    re    = (state_q == S_RD);
    ra    = (idx_q == 5'd0) ? cmd_q.slot[AW-1:0] : waddr[AW-1:0];
    if (pop_o && cmd_i.wr_en) begin
      we = 1'b1;
    end else if (state_q == S_DEC && out_free && elig && differ) begin
      we = 1'b1;
      wa = cmd_q.slot[AW-1:0];
      wd = med;
    end
  end

  // ring store
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if ((state_q == S_RD && idx_q > 5'd1) || state_q == S_LAST) win_q <= win_d;
    if (state_q == S_RD && idx_q == 5'd1) d_q <= rdata_q;
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      a_q          <= '0;
      b_q          <= '0;
      c_q          <= '0;
      m_valid_o    <= 1'b0;
      m_depth_o    <= '0;
      m_replaced_o <= 1'b0;
      m_last_o     <= 1'b0;
    end else begin
      if (m_valid_o && m_ready_i && state_q != S_DEC) m_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          cnt_q <= '0;
          a_q   <= '0;
          b_q   <= '0;
          c_q   <= '0;
          if (pop_o && cmd_i.emit) state_q <= S_RD;
        end
        S_RD: begin
          idx_q <= idx_q + 5'd1;
          if (idx_q > 5'd1) cnt_q <= cnt_q + 5'd1;
          if (idx_q != 5'd0) begin
            if (c_q == 2'd2) begin
              c_q <= '0;
              if (b_q == 2'd2) begin
                b_q <= '0;
                a_q <= a_q + 2'd1;
              end else begin
                b_q <= b_q + 2'd1;
              end
            end else begin
              c_q <= c_q + 2'd1;
            end
          end
          if (idx_q == 5'd27) state_q <= S_LAST;
        end
        S_LAST: begin
          cnt_q   <= cnt_q + 5'd1;
          state_q <= S_DEC;
        end
        S_DEC: begin
          if (out_free) begin
            m_valid_o    <= 1'b1;
            m_depth_o    <= (elig && differ) ? med : d_q;
            m_replaced_o <= elig && differ;
            m_last_o     <= cmd_q.vol_end;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // read index stays within the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (idx_q <= 5'd27))
    else $error("window read index overrun");

  // all but the last window word are sorted when the last one returns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) |-> (cnt_q == 5'd26))
    else $error("sorter count mismatch");

  // a stalled result holds the sequencer in the decision state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC && m_valid_o && !m_ready_i) |=> (state_q == S_DEC))
    else $error("result overwritten while stalled");

  // no command is taken while a window is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pop_o)
    else $error("command popped mid-window");

endmodule

`default_nettype wire

// File: design/volume_median_sign_filter.sv
// ============================================================================
// volume_median_sign_filter
// Streaming in-place 3x3x3 median sign filter over a signed-depth volume.
// ============================================================================
// Back end: a sample that emits no voxel is written to the ring store as it is
//   popped; an item that emits a voxel holds the back end for the 28 reads of
//   the ring store (center plus 27 window words) and the sort/decide steps.
// Queueing: no command is popped while a window is in progress or a result
//   stalls; the front end keeps accepting until its 4-entry queue fills.
// Reset: asynchronous, active low; clears pointers, counts and control
//   registers to their defaults. The ring store and window datapath are not cleared.
`default_nettype none

module volume_median_sign_filter
  import vmsf_pkg::*;
#(
  parameter int MAX_ROW_LEN = 256,
  parameter int MAX_ROWS    = 256
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  // configuration write channel
  input  wire  logic        cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  logic [2:0]  cfg_index_i,
  input  wire  logic [31:0] cfg_data_i,
  // input stream
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [31:0] s_axis_tdata,   // [31:0] depth_in
  input  wire  logic        s_axis_tuser,   // [0] opcode
  // output stream
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] depth_out
  output logic              m_axis_tuser,   // [0] replaced
  output logic              m_axis_tlast    // volume_end
);

  cfg_t cfg_q;
  cmd_t push_cmd, head_cmd;
  logic push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.en    <= 1'b1;
      cfg_q.dim_i <= 16'd256;
      cfg_q.dim_j <= 9'd256;
      cfg_q.dim_k <= 9'd256;
      cfg_q.limit <= 31'd25600000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE: cfg_q.en    <= cfg_data_i[0];
        CFG_DIM_I:  cfg_q.dim_i <= cfg_data_i[15:0];
        CFG_DIM_J:  cfg_q.dim_j <= cfg_data_i[8:0];
        CFG_DIM_K:  cfg_q.dim_k <= cfg_data_i[8:0];
        CFG_LIMIT:  cfg_q.limit <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  vmsf_front #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .opcode_i (s_axis_tuser),
    .depth_i  (s_axis_tdata),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  vmsf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_cmd)
  );

  vmsf_back #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_depth_o    (m_axis_tdata),
    .m_replaced_o (m_axis_tuser),
    .m_last_o     (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: verif/volume_median_sign_filter_tb.sv
// ============================================================================
// volume_median_sign_filter_tb
// Self-checking bench for the streaming 3x3x3 median sign filter.
// Streams depth volumes of several shapes through the block and predicts each
// emitted voxel from a cycle-free copy of the in-place filter. Both stream
// sides idle at random, and settings change between fully drained phases.
// ============================================================================
`default_nettype none

// Scoreboard: predicts emitted voxels and checks each output transaction
class vmsf_scoreboard;
  localparam int RING_DEPTH = 2 * 256 * 256 + 2 * 256 + 3;

  // predictor state
  logic signed [31:0] ring [RING_DEPTH];
  int unsigned wr_ptr, pending, pi, pj, pk, ei, ej, ek;
  bit          en;
  int unsigned di, dj, dk;
  longint      lim;

  // expected voxel: {volume_end, replaced, depth}
  logic [33:0] depth_q[$];
  int errors, checked, n_repl, n_ends;

  function new();
    wr_ptr = 0; pending = 0; pi = 0; pj = 0; pk = 0; ei = 0; ej = 0; ek = 0;
    en = 1; di = 256; dj = 256; dk = 256; lim = 25600000;
    errors = 0; checked = 0; n_repl = 0; n_ends = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      vmsf_pkg::CFG_ENABLE: en = val[0];
      vmsf_pkg::CFG_DIM_I:  di = val[15:0];
      vmsf_pkg::CFG_DIM_J:  dj = val[8:0];
      vmsf_pkg::CFG_DIM_K:  dk = val[8:0];
      vmsf_pkg::CFG_LIMIT:  lim = val[30:0];
      default: ;
    endcase
  endfunction

  function int unsigned clampd(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function void step_pos(ref int unsigned i, ref int unsigned j, ref int unsigned k,
                         input int unsigned ni, nj, nk);
    if (k + 1 < nk) begin
      k++;
      return;
    end
    k = 0;
    if (j + 1 < nj) begin
      j++;
      return;
    end
    j = 0;
    i = (i + 1 < ni) ? i + 1 : 0;
  endfunction

  function bit interior(int unsigned p, int unsigned n);
    return p >= 1 && p + 1 < n;
  endfunction

  // Finalize the oldest pending voxel, median sign test when allowed
  function void emit_voxel(bit may_filter, int unsigned ni, nj, nk);
    longint             plane, off, idx;
    int unsigned        slot;
    logic signed [31:0] d, v;
    logic signed [31:0] win [27];
    int                 n, p;
    bit                 rep, last;
    plane = longint'(nj) * nk;
    slot  = (wr_ptr + RING_DEPTH - pending) % RING_DEPTH;
    d     = ring[slot];
    rep   = 0;
    n     = 0;
    if (may_filter && en && interior(ei, ni) && interior(ej, nj) && interior(ek, nk) &&
        longint'(d) < lim && longint'(d) > -lim) begin
      for (int a = -1; a <= 1; a++)
        for (int b = -1; b <= 1; b++)
          for (int c = -1; c <= 1; c++) begin
            off = a * plane + b * longint'(nk) + c;
            idx = (longint'(slot) + off + RING_DEPTH) % RING_DEPTH;
            v = ring[idx];
            p = n++;
            while (p > 0 && win[p-1] > v) begin
              win[p] = win[p-1];
              p--;
            end
            win[p] = v;
          end
      // sign classes: negative, zero, positive
      if ((win[13] < 0) != (d < 0) || (win[13] == 0) != (d == 0)) begin
        d = win[13];
        ring[slot] = d;
        rep = 1;
      end
    end
    last = (ei + 1 == ni) && (ej + 1 == nj) && (ek + 1 == nk);
    depth_q.push_back({last, rep, d});
    step_pos(ei, ej, ek, ni, nj, nk);
    pending--;
  endfunction

  // Note an accepted input transaction
  function void note_item(vmsf_pkg::opcode_e op, logic [31:0] depth);
    int unsigned ni, nj, nk;
    ni = clampd(di, 65535);
    nj = clampd(dj, 256);
    nk = clampd(dk, 256);
    if (op == vmsf_pkg::OP_DRAIN) begin
      if (pending != 0) emit_voxel(0, ni, nj, nk);
      return;
    end
    ring[wr_ptr] = depth;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    step_pos(pi, pj, pk, ni, nj, nk);
    if (pending < RING_DEPTH) pending++;
    if (pending > nj * nk + nk + 1) emit_voxel(1, ni, nj, nk);
  endfunction

  // Compare an output transaction with the oldest expectation
  function void check_result(logic [31:0] depth, logic repl, logic last);
    logic [33:0] exp_v;
    if (depth_q.size() == 0) begin
      $display("%0t: unexpected voxel depth=%h replaced=%b end=%b", $time, depth, repl, last);
      errors++;
      return;
    end
    exp_v = depth_q.pop_front();
    checked++;
    if (exp_v[32]) n_repl++;
    if (exp_v[33]) n_ends++;
    if (depth !== exp_v[31:0])
      $display("%0t: depth_out exp %h got %h", $time, exp_v[31:0], depth);
    if (repl !== exp_v[32])
      $display("%0t: replaced exp %b got %b", $time, exp_v[32], repl);
    if (last !== exp_v[33])
      $display("%0t: volume_end exp %b got %b", $time, exp_v[33], last);
    if (depth !== exp_v[31:0] || repl !== exp_v[32] || last !== exp_v[33]) errors++;
  endfunction
endclass

module volume_median_sign_filter_tb;
  import vmsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 1500000;
  localparam int     SETTLE      = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_ready = 1'b0;
  wire         cfg_ready_o, s_axis_tready, m_axis_tvalid, m_axis_tuser, m_axis_tlast;
  wire  [31:0] m_axis_tdata;

  bit          idle_on = 1'b1;
  longint      cycles = 0;
  int          n_items = 0;
  vmsf_scoreboard sb = new();

  volume_median_sign_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random back-pressure and result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    m_ready <= !idle_on || ($urandom_range(99) >= 32);
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(opcode_e op, logic [31:0] depth);
    while (idle_on && $urandom_range(99) < 32) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= depth;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, depth);
    n_items++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.depth_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Flush every pending voxel, then settle before any register write
  task automatic flush_phase();
    while (sb.pending != 0) send_item(OP_DRAIN, $urandom);
    wait_drained();
  endtask

  task automatic set_phase(bit en, int di, int dj, int dk, logic [30:0] lim);
    write_cfg(CFG_ENABLE, {31'd0, en});
    write_cfg(CFG_DIM_I, di);
    write_cfg(CFG_DIM_J, dj);
    write_cfg(CFG_DIM_K, dk);
    write_cfg(CFG_LIMIT, {1'b0, lim});
  endtask

  // Random depth: mostly small signed values so median sign flips occur
  function automatic logic [31:0] pick_depth();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 32'd0;
    if (r < 65) return $urandom_range(800) - 400;
    if (r < 75) return $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
    if (r < 85) return $urandom;
    case ($urandom_range(3))
      0: return 32'(sb.lim);
      1: return 32'(-sb.lim);
      2: return 32'(sb.lim - 1);
      default: return 32'(1 - sb.lim);
    endcase
  endfunction

  // Random samples, whole volumes or part of one, with a few drains mixed in
  task automatic run_volumes(int n_samples, bit hold_mid);
    int sent;
    sent = 0;
    while (sent < n_samples) begin
      if ($urandom_range(99) < 3) begin
        send_item(OP_DRAIN, $urandom);
      end else begin
        send_item(OP_SAMPLE, pick_depth());
        sent++;
      end
      if (hold_mid && sent == n_samples / 2) begin
        wait_drained();
        hold_mid = 0;
      end
      idle_on = !(sent > n_samples / 4 && sent < n_samples / 4 + 60);
    end
    idle_on = 1'b1;
    flush_phase();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one 3x3x3 volume, only the center voxel is interior
    set_phase(1'b1, 3, 3, 3, 31'd1000);
    send_item(OP_DRAIN, 32'hFFFF_FFFF);        // nothing pending: no result
    for (int n = 0; n < 27; n++) begin
      case (n)
        0:  send_item(OP_SAMPLE, 32'h7FFF_FFFF);
        1:  send_item(OP_SAMPLE, 32'h8000_0000);
        2:  send_item(OP_SAMPLE, 32'd0);
        13: send_item(OP_SAMPLE, 32'd5);       // positive center, negative field
        26: send_item(OP_SAMPLE, 32'h5555_5555);
        default: send_item(OP_SAMPLE, -(n * 3));
      endcase
    end
    flush_phase();

    // Random phases over shapes, limits and bypass
    set_phase(1'b1, 4, 5, 6, 31'h7FFF_FFFF);
    run_volumes(360, 1'b1);
    set_phase(1'b0, 3, 4, 3, 31'd1000);
    run_volumes(72, 1'b0);
    set_phase(1'b1, 5, 3, 4, 31'd300);
    run_volumes(240, 1'b0);
    set_phase(1'b1, 3, 3, 24, 31'h7FFF_FFFF);
    run_volumes(216, 1'b0);
    // Largest sizes last: only a partial volume, emptied by drains
    set_phase(1'b1, 65535, 256, 256, 31'd0);
    run_volumes(50, 1'b0);

    wait_drained();
    $display("covered %0d input transactions over 6 volume shapes, bypass and limit extremes",
             n_items);
    $display("checked %0d voxels, %0d replaced by the median, %0d volume ends",
             sb.checked, sb.n_repl, sb.n_ends);
    if (sb.errors == 0 && sb.depth_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
